// ===== hdl/wfe_pkg.sv =====
// Shared types and constants for the Wiegand frame encoder.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package wfe_pkg;

  localparam int unsigned FRAME_W    = 64;  // frame_bits width
  localparam int unsigned LEN_W      = 7;   // frame_length width
  localparam int unsigned FLD_W      = 32;  // one input field
  localparam int unsigned FLEN_W     = 6;   // field length register
  localparam int unsigned POS_W      = 6;   // frame position
  localparam int unsigned PREG_W     = 7;   // signed parity position register
  localparam int unsigned STREAM_W   = 96;  // three fields back to back
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURESS_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ODD_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_POS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ODD_POS    = 3'd6;

  // reset layout: 26-bit frame
  localparam logic [FLEN_W-1:0]  RST_DEVICE_LEN = 6'd8;
  localparam logic [FLEN_W-1:0]  RST_CARD_LEN   = 6'd16;
  localparam logic [FLEN_W-1:0]  RST_DURESS_LEN = 6'd0;
  localparam logic [FRAME_W-1:0] RST_EVEN_MASK  = 64'd8190;
  localparam logic [FRAME_W-1:0] RST_ODD_MASK   = 64'd33546240;
  localparam logic [PREG_W-1:0]  RST_EVEN_POS   = 7'd0;
  localparam logic [PREG_W-1:0]  RST_ODD_POS    = 7'd25;

  typedef struct packed {
    logic [FLD_W-1:0] device_id;
    logic [FLD_W-1:0] card_number;
    logic [FLD_W-1:0] duress_id;
  } wfe_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_bits;
    logic [LEN_W-1:0]   frame_length;
  } wfe_out_t;

  // decoded layout, derived from the configuration registers
  typedef struct packed {
    logic [FLEN_W-1:0]  dev_len;
    logic [FLEN_W-1:0]  card_len;
    logic [FLEN_W-1:0]  dur_len;
    logic [FRAME_W-1:0] even_mask;
    logic [FRAME_W-1:0] odd_mask;
    logic               even_on;
    logic               odd_on;
    logic [POS_W-1:0]   even_pos;
    logic [POS_W-1:0]   odd_pos;
    logic [LEN_W-1:0]   frame_length;
  } wfe_cfg_t;

endpackage

// ===== hdl/wfe_cfg_regs.sv =====
// Configuration register file and layout decode for the Wiegand frame encoder.
// Depends on wfe_pkg.
module wfe_cfg_regs #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [wfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wfe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output wfe_pkg::wfe_cfg_t                cfg_o
);

  localparam logic [wfe_pkg::FRAME_W:0] MaskWide =
    (65'(1) << MAX_FRAME_BITS) - 65'd1;
  localparam logic [wfe_pkg::FRAME_W-1:0] FrameMask = MaskWide[wfe_pkg::FRAME_W-1:0];
  localparam logic [wfe_pkg::LEN_W-1:0]   MaxBits   = wfe_pkg::LEN_W'(MAX_FRAME_BITS);
  localparam logic [wfe_pkg::FLEN_W-1:0]  FieldMax  = 6'd32;

  logic [wfe_pkg::FLEN_W-1:0]  dev_len_q, card_len_q, dur_len_q;
  logic [wfe_pkg::FRAME_W-1:0] even_mask_q, odd_mask_q;
  logic [wfe_pkg::PREG_W-1:0]  even_pos_q, odd_pos_q;

  logic                        even_pos_ok, odd_pos_ok;
  logic [wfe_pkg::LEN_W-1:0]   len_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_len_q   <= wfe_pkg::RST_DEVICE_LEN;
      card_len_q  <= wfe_pkg::RST_CARD_LEN;
      dur_len_q   <= wfe_pkg::RST_DURESS_LEN;
      even_mask_q <= wfe_pkg::RST_EVEN_MASK;
      odd_mask_q  <= wfe_pkg::RST_ODD_MASK;
      even_pos_q  <= wfe_pkg::RST_EVEN_POS;
      odd_pos_q   <= wfe_pkg::RST_ODD_POS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wfe_pkg::REG_DEVICE_LEN: dev_len_q   <= cfg_data_i[wfe_pkg::FLEN_W-1:0];
        wfe_pkg::REG_CARD_LEN:   card_len_q  <= cfg_data_i[wfe_pkg::FLEN_W-1:0];
        wfe_pkg::REG_DURESS_LEN: dur_len_q   <= cfg_data_i[wfe_pkg::FLEN_W-1:0];
        wfe_pkg::REG_EVEN_MASK:  even_mask_q <= cfg_data_i[wfe_pkg::FRAME_W-1:0];
        wfe_pkg::REG_ODD_MASK:   odd_mask_q  <= cfg_data_i[wfe_pkg::FRAME_W-1:0];
        wfe_pkg::REG_EVEN_POS:   even_pos_q  <= cfg_data_i[wfe_pkg::PREG_W-1:0];
        wfe_pkg::REG_ODD_POS:    odd_pos_q   <= cfg_data_i[wfe_pkg::PREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // lengths above 32 saturate
    cfg_o.dev_len  = (dev_len_q  > FieldMax) ? FieldMax : dev_len_q;
    cfg_o.card_len = (card_len_q > FieldMax) ? FieldMax : card_len_q;
    cfg_o.dur_len  = (dur_len_q  > FieldMax) ? FieldMax : dur_len_q;

    cfg_o.even_mask = even_mask_q & FrameMask;
    cfg_o.odd_mask  = odd_mask_q  & FrameMask;
    cfg_o.even_pos  = even_pos_q[wfe_pkg::POS_W-1:0];
    cfg_o.odd_pos   = odd_pos_q[wfe_pkg::POS_W-1:0];

    // negative or out-of-frame position means no parity bit
    even_pos_ok = !even_pos_q[wfe_pkg::PREG_W-1] &&
                  ({1'b0, even_pos_q[wfe_pkg::POS_W-1:0]} < MaxBits);
    odd_pos_ok  = !odd_pos_q[wfe_pkg::PREG_W-1] &&
                  ({1'b0, odd_pos_q[wfe_pkg::POS_W-1:0]} < MaxBits);
    cfg_o.even_on = even_pos_ok && (cfg_o.even_mask != '0);
    cfg_o.odd_on  = odd_pos_ok  && (cfg_o.odd_mask  != '0);

    // a shared parity position counts once
    len_sum = wfe_pkg::LEN_W'(cfg_o.dev_len) + wfe_pkg::LEN_W'(cfg_o.card_len)
            + wfe_pkg::LEN_W'(cfg_o.dur_len) + wfe_pkg::LEN_W'(cfg_o.odd_on)
            + wfe_pkg::LEN_W'(cfg_o.even_on &&
                              !(cfg_o.odd_on && (cfg_o.odd_pos == cfg_o.even_pos)));
    cfg_o.frame_length = (len_sum > MaxBits) ? MaxBits : len_sum;
  end

endmodule

// ===== hdl/wfe_place.sv =====
// Data bit placement: packs the three fields MSB first and opens gaps at the
// enabled parity positions. Depends on wfe_pkg.
module wfe_place (
  input  wfe_pkg::wfe_in_t                item_i,
  input  wfe_pkg::wfe_cfg_t               cfg_i,
  output logic [wfe_pkg::FRAME_W-1:0]     data_frame_o
);

  localparam logic [6:0] StreamTop = 7'(wfe_pkg::STREAM_W);

  logic [wfe_pkg::FLD_W:0]      dev_m, card_m, dur_m;
  logic [6:0]                   sh_dev, sh_card, sh_dur;
  logic [wfe_pkg::STREAM_W-1:0] stream;
  logic [wfe_pkg::FRAME_W-1:0]  d, d1, d2;
  logic [wfe_pkg::FRAME_W-1:0]  gt_a, gt_b, at_a, at_b, sh0, sh1, sh2;
  logic                         gap_a_v, gap_b_v;
  logic [wfe_pkg::POS_W-1:0]    gap_a, gap_b;

  always_comb begin
    // field masks from 33-bit arithmetic so a length of 32 keeps every bit
    dev_m  = ((33'(1) << cfg_i.dev_len)  - 33'd1) & {1'b0, item_i.device_id};
    card_m = ((33'(1) << cfg_i.card_len) - 33'd1) & {1'b0, item_i.card_number};
    dur_m  = ((33'(1) << cfg_i.dur_len)  - 33'd1) & {1'b0, item_i.duress_id};

    // stream bit j sits at stream[95-j]
    sh_dev  = StreamTop - 7'(cfg_i.dev_len);
    sh_card = sh_dev  - 7'(cfg_i.card_len);
    sh_dur  = sh_card - 7'(cfg_i.dur_len);
    stream  = (wfe_pkg::STREAM_W'(dev_m)  << sh_dev)
            | (wfe_pkg::STREAM_W'(card_m) << sh_card)
            | (wfe_pkg::STREAM_W'(dur_m)  << sh_dur);

    for (int j = 0; j < wfe_pkg::FRAME_W; j++) begin
      d[j] = stream[wfe_pkg::STREAM_W-1-j];
    end
    d1 = {d[wfe_pkg::FRAME_W-2:0], 1'b0};
    d2 = {d[wfe_pkg::FRAME_W-3:0], 2'b0};

    // sorted gaps, a below b
    gap_a_v = 1'b0;
    gap_b_v = 1'b0;
    gap_a   = cfg_i.even_pos;
    gap_b   = cfg_i.odd_pos;
    if (cfg_i.even_on && cfg_i.odd_on && (cfg_i.even_pos != cfg_i.odd_pos)) begin
      gap_a_v = 1'b1;
      gap_b_v = 1'b1;
      if (cfg_i.odd_pos < cfg_i.even_pos) begin
        gap_a = cfg_i.odd_pos;
        gap_b = cfg_i.even_pos;
      end
    end else if (cfg_i.even_on) begin
      gap_a_v = 1'b1;
    end else if (cfg_i.odd_on) begin
      gap_a_v = 1'b1;
      gap_a   = cfg_i.odd_pos;
    end

    for (int k = 0; k < wfe_pkg::FRAME_W; k++) begin
      gt_a[k] = gap_a_v && (wfe_pkg::POS_W'(k) >  gap_a);
      gt_b[k] = gap_b_v && (wfe_pkg::POS_W'(k) >  gap_b);
      at_a[k] = gap_a_v && (wfe_pkg::POS_W'(k) == gap_a);
      at_b[k] = gap_b_v && (wfe_pkg::POS_W'(k) == gap_b);
    end

    // past gap b is also past gap a
    sh0 = ~(gt_a | gt_b);
    sh1 = gt_a ^ gt_b;
    sh2 = gt_a & gt_b;
    data_frame_o = ((d & sh0) | (d1 & sh1) | (d2 & sh2)) & ~(at_a | at_b);
  end

endmodule

// ===== hdl/wfe_parity.sv =====
// Parity insertion: odd bit first, then even parity over the updated frame.
// Depends on wfe_pkg.
module wfe_parity #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic [wfe_pkg::FRAME_W-1:0] data_frame_i,
  input  wfe_pkg::wfe_cfg_t           cfg_i,
  output logic [wfe_pkg::FRAME_W-1:0] frame_bits_o
);

  localparam logic [wfe_pkg::FRAME_W:0] MaskWide =
    (65'(1) << MAX_FRAME_BITS) - 65'd1;
  localparam logic [wfe_pkg::FRAME_W-1:0] FrameMask = MaskWide[wfe_pkg::FRAME_W-1:0];

  logic                        odd_bit, even_bit;
  logic [wfe_pkg::FRAME_W-1:0] with_odd, with_even;

  always_comb begin
    odd_bit   = cfg_i.odd_on && !(^(data_frame_i & cfg_i.odd_mask));
    with_odd  = data_frame_i | (wfe_pkg::FRAME_W'(odd_bit) << cfg_i.odd_pos);
    // even parity sees the odd bit when it lies in the even range
    even_bit  = cfg_i.even_on && (^(with_odd & cfg_i.even_mask));
    with_even = with_odd | (wfe_pkg::FRAME_W'(even_bit) << cfg_i.even_pos);
    frame_bits_o = with_even & FrameMask;
  end

endmodule

// ===== hdl/wiegand_frame_encoder.sv =====
// Wiegand frame encoder, top level: handshake, item and result registers.
// Depends on wfe_pkg, wfe_cfg_regs, wfe_place and wfe_parity.
//
// Use:
//   Input channel in_valid_i/in_ready_o carries one wfe_in_t beat (device ID,
//   card number, duress ID). Output channel out_valid_o/out_ready_i returns one
//   wfe_out_t beat per input: frame bits (bit k = position k, sent first at 0)
//   and the frame length.
//   Configuration channel cfg_valid_i/cfg_ready_o writes one register per beat
//   (cfg_index_i selects it); it is always ready. Write only while idle.
// Timing:
//   An item is captured in the item register, then placement and parity run in
//   one pass of logic into the result register, which drives out_valid_o;
//   one item per cycle sustained while out_ready_i is high. The single logic
//   pass between the two registers sets that rate.
// Reset:
//   Both stages empty, registers back to the 26-bit layout.
// Stall:
//   With out_ready_i low the result holds; one more item waits in the item
//   register, after which in_ready_o drops until the result is taken.
module wiegand_frame_encoder #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wfe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wfe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wfe_pkg::wfe_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wfe_pkg::wfe_out_t               out_data_o
);

  localparam logic [wfe_pkg::FRAME_W:0] MaskWide =
    (65'(1) << MAX_FRAME_BITS) - 65'd1;
  localparam logic [wfe_pkg::FRAME_W-1:0] FrameMask = MaskWide[wfe_pkg::FRAME_W-1:0];

  wfe_pkg::wfe_cfg_t           cfg;
  wfe_pkg::wfe_in_t            item_q;
  wfe_pkg::wfe_out_t           res_q, res_d;
  logic                        item_valid_q, res_valid_q;
  logic                        in_fire, res_load;
  logic [wfe_pkg::FRAME_W-1:0] data_frame;
  logic [wfe_pkg::FRAME_W-1:0] frame_bits;

  assign cfg_ready_o = 1'b1;

  wfe_cfg_regs #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wfe_place u_place (
    .item_i       (item_q),
    .cfg_i        (cfg),
    .data_frame_o (data_frame)
  );

  wfe_parity #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_parity (
    .data_frame_i (data_frame),
    .cfg_i        (cfg),
    .frame_bits_o (frame_bits)
  );

  assign res_d = '{frame_bits: frame_bits, frame_length: cfg.frame_length};

  assign res_load   = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || res_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_valid_q <= 1'b1;
      end else if (res_load) begin
        item_valid_q <= 1'b0;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // a waiting item must not move while the result stage is blocked
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !res_load |=> item_valid_q && $stable(item_q))
    else $error("item register changed while blocked");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_o)
    else $error("loaded result not presented");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_length <= wfe_pkg::LEN_W'(MAX_FRAME_BITS))
    else $error("frame length above frame size");

  a_frame_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.frame_bits & ~FrameMask) == '0)
    else $error("frame bit set beyond frame size");

endmodule
